// ===== hdl/huffman_tree_bit_decoder_macros.svh =====
// Assertion macros shared by the checker of the tree-walking Huffman decoder.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef HUFFMAN_TREE_BIT_DECODER_MACROS_SVH
`define HUFFMAN_TREE_BIT_DECODER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define HTBD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HTBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/htbd_pkg.sv =====
// Types and constants of the tree-walking Huffman decoder.
// No dependencies; used by the decoder top level and by its checker.
`default_nettype none

package htbd_pkg;

	localparam int NODE_COUNT = 256;
	localparam int IDX_W      = 8;
	localparam int SYM_W      = 8;

	// Item operation codes.
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	// One entry of the node table, 25 bits.
	typedef struct packed {
		logic             leaf;
		logic [SYM_W-1:0] sym;
		logic [IDX_W-1:0] child_one;
		logic [IDX_W-1:0] child_zero;
	} node_t;

	// Walk sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_NODE,
		ST_CHILD
	} state_t;

endpackage

`default_nettype wire

// ===== hdl/huffman_tree_bit_decoder.sv =====
// Bit-serial Huffman decoder that walks a node table held in one synchronous memory.
// Depends on htbd_pkg for the entry layout, operation codes and sequencer states.
//
//   channel  handshake              carries
//   in       in_valid / in_stall    op, node_index, node_is_leaf, node_symbol,
//                                   child_one, child_zero, code_bit, restart
//   out      out_valid / out_stall  symbol
//   config   cfg_we / cfg_data      root_node (no read-back)
//
// A write-node transfer is written to the table as it is taken and issues no read.
// A decode transfer reads the current node's entry and then the chosen child's entry
// in turn through the single read port, and the second read decides leaf or not.
// A leaf result is loaded into the output register from the ST_CHILD state.
// Reset clears the sequencer, root, walk position and out_valid; the table stays undefined.
// A waiting result does not block input; only a new leaf hit waits for it to leave.
`default_nettype none

module huffman_tree_bit_decoder (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// configuration
	input  wire logic                      cfg_we,
	input  wire logic [htbd_pkg::IDX_W-1:0] cfg_data,
	// input channel
	input  wire logic                      in_valid,
	output      logic                      in_stall,
	input  wire logic                      op,
	input  wire logic [htbd_pkg::IDX_W-1:0] node_index,
	input  wire logic                      node_is_leaf,
	input  wire logic [htbd_pkg::SYM_W-1:0] node_symbol,
	input  wire logic [htbd_pkg::IDX_W-1:0] child_one,
	input  wire logic [htbd_pkg::IDX_W-1:0] child_zero,
	input  wire logic                      code_bit,
	input  wire logic                      restart,
	// output channel
	output      logic                      out_valid,
	input  wire logic                      out_stall,
	output      logic [htbd_pkg::SYM_W-1:0] symbol
);

	// The node table. Entries are only defined once written.
	htbd_pkg::node_t node_mem [htbd_pkg::NODE_COUNT];

	htbd_pkg::state_t state_q, state_nxt;

	logic [htbd_pkg::IDX_W-1:0] root_q;
	logic [htbd_pkg::IDX_W-1:0] cur_q;
	logic                       bit_s1;
	logic [htbd_pkg::IDX_W-1:0] child_s2;
	htbd_pkg::node_t            rd_data_q;
	logic                       out_valid_q;
	logic [htbd_pkg::SYM_W-1:0] symbol_q;

	logic                       stall_c;
	logic                       rd_en;
	logic [htbd_pkg::IDX_W-1:0] rd_addr;
	logic                       emit;
	logic                       accept_in;
	logic                       step_done;
	logic [htbd_pkg::IDX_W-1:0] walk_next;
	logic [htbd_pkg::IDX_W-1:0] walk_from;

	assign accept_in = in_valid && !stall_c;

	// The second read of a bit may finish unless it hits a leaf while the
	// output register still holds a result that is not taken this cycle.
	assign step_done = !rd_data_q.leaf || !out_valid_q || !out_stall;

	// Where the walk stands once the child read completes.
	assign walk_next = rd_data_q.leaf ? root_q : child_s2;

	// Start node of a new decode item: the root on restart; otherwise, when a bit
	// finishes in the same cycle, its outcome is forwarded straight into the read address.
	always_comb begin
		if (restart) begin
			walk_from = root_q;
		end else if (state_q == htbd_pkg::ST_CHILD) begin
			walk_from = walk_next;
		end else begin
			walk_from = cur_q;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			htbd_pkg::ST_IDLE: begin
				if (accept_in && op == htbd_pkg::OP_DECODE) begin
					state_nxt = htbd_pkg::ST_NODE;
				end
			end
			htbd_pkg::ST_NODE: begin
				state_nxt = htbd_pkg::ST_CHILD;
			end
			htbd_pkg::ST_CHILD: begin
				if (step_done) begin
					if (accept_in && op == htbd_pkg::OP_DECODE) begin
						state_nxt = htbd_pkg::ST_NODE;
					end else begin
						state_nxt = htbd_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = htbd_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs: input stall, read port control and result load.
	always_comb begin
		stall_c = 1'b1;
		rd_en   = 1'b0;
		rd_addr = walk_from;
		emit    = 1'b0;
		unique case (state_q)
			htbd_pkg::ST_IDLE: begin
				stall_c = 1'b0;
				rd_en   = in_valid && op == htbd_pkg::OP_DECODE;
			end
			htbd_pkg::ST_NODE: begin
				rd_en   = 1'b1;
				rd_addr = bit_s1 ? rd_data_q.child_one : rd_data_q.child_zero;
			end
			htbd_pkg::ST_CHILD: begin
				stall_c = !step_done;
				rd_en   = step_done && in_valid && op == htbd_pkg::OP_DECODE;
				emit    = step_done && rd_data_q.leaf;
			end
			default: begin
				stall_c = 1'b1;
			end
		endcase
	end

	// Table write port. Writes and reads never meet at the same edge, since a
	// transfer is only taken in cycles where no child read is issued.
	always_ff @(posedge clk) begin
		if (accept_in && op == htbd_pkg::OP_WRITE) begin
			node_mem[node_index] <= '{leaf:       node_is_leaf,
			                          sym:        node_symbol,
			                          child_one:  child_one,
			                          child_zero: child_zero};
		end
	end

	// Table read port. The data register holds while no read is issued, so a
	// leaf hit that waits on the output keeps its entry.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= node_mem[rd_addr];
		end
	end

	// Payload pipeline registers.
	always_ff @(posedge clk) begin
		if (accept_in) begin
			bit_s1 <= code_bit;
		end
		if (state_q == htbd_pkg::ST_NODE) begin
			child_s2 <= rd_addr;
		end
		if (emit) begin
			symbol_q <= rd_data_q.sym;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= htbd_pkg::ST_IDLE;
			root_q      <= '0;
			cur_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				root_q <= cfg_data;
				cur_q  <= cfg_data;
			end else if (state_q == htbd_pkg::ST_CHILD && step_done) begin
				cur_q <= walk_next;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = stall_c;
	assign out_valid = out_valid_q;
	assign symbol    = symbol_q;

endmodule

`default_nettype wire

// ===== hdl/htbd_checker.sv =====
// Port-level checker for the tree-walking Huffman decoder, bound to its top level.
// Depends on htbd_pkg and on huffman_tree_bit_decoder_macros.svh.
`default_nettype none

`include "huffman_tree_bit_decoder_macros.svh"

module htbd_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_stall,
	input wire logic                       op,
	input wire logic                       out_valid,
	input wire logic                       out_stall,
	input wire logic [htbd_pkg::SYM_W-1:0] symbol
);

	// A result that is stalled stays offered unchanged.
	`HTBD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(symbol), "stalled result changed")

	// After a decode transfer the block stalls input while it reads the chosen child's entry.
	`HTBD_ASSERT_NEXT(a_decode_busy, clk, arst_n, in_valid && !in_stall && op == htbd_pkg::OP_DECODE, in_stall, "decode transfer not followed by a busy cycle")

	// A new result always comes from a decode transfer, by way of ST_NODE and ST_CHILD.
	`HTBD_ASSERT_SAME(a_result_origin, clk, arst_n, $rose(out_valid), $past(in_valid && !in_stall && op == htbd_pkg::OP_DECODE, 3), "result without a matching decode transfer")

endmodule

bind huffman_tree_bit_decoder htbd_checker u_htbd_checker (.*);

`default_nettype wire
